[hw/rtl/csv_field_tokenizer_assert.svh]
// assertion macros shared by the tokenizer modules
`ifndef CSV_FIELD_TOKENIZER_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_ASSERT_SVH

// check held outside reset
`define CSVFT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("csv tokenizer check failed");

// check held at every edge, reset included
`define CSVFT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("csv tokenizer check failed");

`endif

[hw/rtl/csvft_pkg.sv]
// types, codes and character helpers for the csv field tokenizer
package csvft_pkg;

  localparam int CSVFT_QDEPTH = 4;

  // parser modes
  typedef enum logic [2:0] {
    M_REC    = 3'd0,
    M_FSTART = 3'd1,
    M_UNQ    = 3'd2,
    M_QUO    = 3'd3,
    M_QSEEN  = 3'd4,
    M_AFTERQ = 3'd5,
    M_DROP   = 3'd6
  } mode_t;

  // result event kinds
  typedef enum logic [1:0] {
    EV_BYTE = 2'd0,
    EV_FEND = 2'd1,
    EV_REND = 2'd2,
    EV_ERR  = 2'd3
  } ev_t;

  // error codes
  typedef enum logic [1:0] {
    ERR_SEP    = 2'd0,
    ERR_UNTERM = 2'd1,
    ERR_QUOTE  = 2'd2
  } err_t;

  // queued operations: one queue entry per input that gives results
  typedef enum logic [1:0] {
    OP_BYTE      = 2'd0,
    OP_FEND      = 2'd1,
    OP_FEND_REND = 2'd2,
    OP_ERR       = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    err_t       code;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SUB   = 8'h1A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_break(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF) || (c == CH_SUB);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

endpackage

[hw/rtl/csvft_front.sv]
// front end: accepts bytes, tracks the parser mode and queues result operations
module csvft_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        text_byte,
  input  logic              end_of_input,
  input  csvft_pkg::q_stat_t q_stat,
  output logic              push,
  output csvft_pkg::cmd_t   push_cmd
);
  import csvft_pkg::*;

  mode_t mode;
  mode_t mode_next;
  logic  accept;
  logic  has_cmd;
  logic  do_fstart;
  logic  do_afterq;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && has_cmd;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_REC;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

  // classify the byte against the current mode
  always_comb begin
    mode_next     = mode;
    has_cmd       = 1'b0;
    push_cmd.op   = OP_BYTE;
    push_cmd.data = text_byte;
    push_cmd.code = ERR_SEP;
    do_fstart     = 1'b0;
    do_afterq     = 1'b0;
    if (end_of_input) begin
      mode_next = M_REC;
      case (mode)
        M_FSTART, M_UNQ, M_QSEEN, M_AFTERQ: begin
          has_cmd     = 1'b1;
          push_cmd.op = OP_FEND_REND;
        end
        M_QUO: begin
          has_cmd       = 1'b1;
          push_cmd.op   = OP_ERR;
          push_cmd.code = ERR_UNTERM;
        end
        default: ;
      endcase
    end else begin
      case (mode)
        M_FSTART: do_fstart = 1'b1;
        M_UNQ: begin
          if (text_byte == CH_COMMA) begin
            mode_next   = M_FSTART;
            has_cmd     = 1'b1;
            push_cmd.op = OP_FEND;
          end else if (is_break(text_byte)) begin
            mode_next   = (text_byte == CH_SUB) ? M_DROP : M_REC;
            has_cmd     = 1'b1;
            push_cmd.op = OP_FEND_REND;
          end else if (text_byte == CH_QUOTE) begin
            mode_next     = M_DROP;
            has_cmd       = 1'b1;
            push_cmd.op   = OP_ERR;
            push_cmd.code = ERR_QUOTE;
          end else begin
            has_cmd = 1'b1;
          end
        end
        M_QUO: begin
          if (is_break(text_byte)) begin
            mode_next     = is_eol(text_byte) ? M_REC : M_DROP;
            has_cmd       = 1'b1;
            push_cmd.op   = OP_ERR;
            push_cmd.code = ERR_UNTERM;
          end else if (text_byte == CH_QUOTE) begin
            mode_next = M_QSEEN;
          end else begin
            has_cmd = 1'b1;
          end
        end
        M_QSEEN: begin
          if (text_byte == CH_QUOTE) begin
            mode_next = M_QUO;
            has_cmd   = 1'b1;
          end else begin
            do_afterq = 1'b1;
          end
        end
        M_AFTERQ: do_afterq = 1'b1;
        M_DROP: begin
          if (is_eol(text_byte)) mode_next = M_REC;
        end
        default: begin
          if (is_eol(text_byte)) begin
            mode_next = M_REC;
          end else begin
            do_fstart = 1'b1;
          end
        end
      endcase

      // start of a field: blanks skipped, quote opens a quoted field
      if (do_fstart) begin
        if (is_blank(text_byte)) begin
          mode_next = M_FSTART;
        end else if (text_byte == CH_QUOTE) begin
          mode_next = M_QUO;
        end else if (text_byte == CH_COMMA) begin
          mode_next   = M_FSTART;
          has_cmd     = 1'b1;
          push_cmd.op = OP_FEND;
        end else if (is_break(text_byte)) begin
          mode_next   = (text_byte == CH_SUB) ? M_DROP : M_REC;
          has_cmd     = 1'b1;
          push_cmd.op = OP_FEND_REND;
        end else begin
          mode_next = M_UNQ;
          has_cmd   = 1'b1;
        end
      end

      // after a closing quote only blanks may come before the separator
      if (do_afterq) begin
        if (is_blank(text_byte)) begin
          mode_next = M_AFTERQ;
        end else if (text_byte == CH_COMMA) begin
          mode_next   = M_FSTART;
          has_cmd     = 1'b1;
          push_cmd.op = OP_FEND;
        end else if (is_break(text_byte)) begin
          mode_next   = (text_byte == CH_SUB) ? M_DROP : M_REC;
          has_cmd     = 1'b1;
          push_cmd.op = OP_FEND_REND;
        end else begin
          mode_next     = M_DROP;
          has_cmd       = 1'b1;
          push_cmd.op   = OP_ERR;
          push_cmd.code = ERR_SEP;
        end
      end
    end
  end

endmodule

[hw/rtl/csvft_queue.sv]
// short queue of result operations between front and back ends
module csvft_queue #(
  parameter int QDEPTH = csvft_pkg::CSVFT_QDEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  csvft_pkg::cmd_t    push_cmd,
  input  logic               pop,
  output csvft_pkg::cmd_t    head,
  output csvft_pkg::q_stat_t q_stat
);
  import csvft_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(QDEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(QDEPTH);

  cmd_t          mem [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign q_stat.full  = (count == FULL);
  assign q_stat.empty = (count == '0);
  assign head         = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `include "csv_field_tokenizer_assert.svh"

  `CSVFT_ASSERT(a_no_push_full, !(push && q_stat.full))
  `CSVFT_ASSERT(a_no_pop_empty, !(pop && q_stat.empty))
  `CSVFT_ASSERT_ALWAYS(a_count_bound, rst || (count <= FULL))

endmodule

[hw/rtl/csvft_back.sv]
// back end: expands queued operations into result transfers through an output register
module csvft_back (
  input  logic               clk,
  input  logic               rst,
  input  csvft_pkg::cmd_t    head,
  input  csvft_pkg::q_stat_t q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         event_kind,
  output logic [7:0]         field_byte,
  output logic [1:0]         error_code,
  output logic               last_of_run
);
  import csvft_pkg::*;

  logic       phase;
  logic       load;
  ev_t        ev_next;
  logic [7:0] byte_next;
  err_t       code_next;
  logic       last_next;

  assign load = (!out_valid || out_ready) && !q_stat.empty;
  // a field-and-record end stays at the head for its second result
  assign pop  = load && ((head.op != OP_FEND_REND) || phase);

  // result for the head operation
  always_comb begin
    ev_next   = EV_FEND;
    byte_next = '0;
    code_next = ERR_SEP;
    last_next = 1'b1;
    case (head.op)
      OP_BYTE: begin
        ev_next   = EV_BYTE;
        byte_next = head.data;
      end
      OP_FEND: ev_next = EV_FEND;
      OP_FEND_REND: begin
        ev_next   = phase ? EV_REND : EV_FEND;
        last_next = phase;
      end
      OP_ERR: begin
        ev_next   = EV_ERR;
        code_next = head.code;
      end
      default: ;
    endcase
  end

  // control: output valid and expansion phase
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (load && head.op == OP_FEND_REND) phase <= !phase;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      event_kind  <= ev_next;
      field_byte  <= byte_next;
      error_code  <= code_next;
      last_of_run <= last_next;
    end
  end

  `include "csv_field_tokenizer_assert.svh"

  `CSVFT_ASSERT(a_phase_head, !phase || (!q_stat.empty && head.op == OP_FEND_REND))
  `CSVFT_ASSERT(a_hold_stalled, (out_valid && !out_ready) |=> (out_valid && $stable(event_kind)))
  `CSVFT_ASSERT(a_rend_follows, (load && phase) |-> (ev_next == EV_REND && last_next))

endmodule

[hw/rtl/csv_field_tokenizer.sv]
// csv field tokenizer: byte stream in, field bytes, field ends, record ends and errors out
//
// Input channel (in_valid/in_ready) takes one text_byte per transfer, or an end mark when
// end_of_input is high. Output channel (out_valid/out_ready) gives one result per transfer:
// event_kind, field_byte, error_code and last_of_run, which flags the final result of an input.
// Each input gives zero, one or two results. A byte taken is written into the result queue and
// then loaded into the output register before its first result transfer. One input is taken
// per cycle while the result queue has room; results leave at one per cycle while the receiver
// is ready, so a line break that closes a record (field end and record end) gives the back end
// two results. The front end keeps a three-bit parser mode.
// A queue of QDEPTH operations sits between the mode tracker and the output register, so a
// stalled receiver fills the queue before in_ready drops; bytes that give no result still
// need a free queue slot to be taken. Reset (synchronous, rst high) empties the queue,
// drops the output and returns the parser to record start with line breaks skipped.
module csv_field_tokenizer #(
  parameter int QDEPTH = csvft_pkg::CSVFT_QDEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] event_kind,
  output logic [7:0] field_byte,
  output logic [1:0] error_code,
  output logic       last_of_run
);
  import csvft_pkg::*;

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    head;
  logic    push;
  logic    pop;

  // mode tracking and classification
  csvft_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .end_of_input (end_of_input),
    .q_stat       (q_stat),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  // decoupling queue
  csvft_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // result expansion and output register
  csvft_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .field_byte  (field_byte),
    .error_code  (error_code),
    .last_of_run (last_of_run)
  );

endmodule

[bench/csv_field_tokenizer_test.sv]
// self-checking testbench for the csv field tokenizer: directed and random csv text, checked per result
module csv_field_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import csvft_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int CALM_ITEMS   = 150;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [7:0] text;
    logic       eoi;
  } text_item_t;

  typedef struct {
    ev_t        kind;
    logic [7:0] data;
    err_t       code;
    logic       last;
  } token_event_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] text_byte = 8'h00;
  logic       end_of_input = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] event_kind;
  logic [7:0] field_byte;
  logic [1:0] error_code;
  logic       last_of_run;

  text_item_t   text_queue[$];
  token_event_t pending_events[$];
  mode_t        parse_mode = M_REC;

  int  mismatches = 0;
  int  results_seen = 0;
  int  cycles = 0;
  int  items_sent = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  in_rate = 2;
  int  out_rate = 2;
  bit  in_fire = 1'b0;
  bit  calm = 1'b0;

  csv_field_tokenizer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .field_byte   (field_byte),
    .error_code   (error_code),
    .last_of_run  (last_of_run)
  );

  // clock, 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // reset held high from the start, released on a falling edge
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // character classes of the tokenizer
  function automatic bit line_end(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic bit record_break(input logic [7:0] c);
    return line_end(c) || (c == CH_SUB);
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  // expected result store
  function automatic void add_event(input ev_t kind, input logic [7:0] data, input err_t code);
    token_event_t e;
    e.kind = kind;
    e.data = data;
    e.code = code;
    e.last = 1'b0;
    pending_events.push_back(e);
  endfunction

  function automatic void close_record(input logic [7:0] c);
    add_event(EV_FEND, 8'h00, ERR_SEP);
    add_event(EV_REND, 8'h00, ERR_SEP);
    // a sub character ends the record but the line runs on until cr/lf
    parse_mode = (c == CH_SUB) ? M_DROP : M_REC;
  endfunction

  function automatic void raise_error(input logic [7:0] c, input err_t code);
    parse_mode = line_end(c) ? M_REC : M_DROP;
    add_event(EV_ERR, 8'h00, code);
  endfunction

  function automatic void start_field(input logic [7:0] c);
    if (blank_char(c)) begin
      parse_mode = M_FSTART;
    end else if (c == CH_QUOTE) begin
      parse_mode = M_QUO;
    end else if (c == CH_COMMA) begin
      parse_mode = M_FSTART;
      add_event(EV_FEND, 8'h00, ERR_SEP);
    end else if (record_break(c)) begin
      close_record(c);
    end else begin
      parse_mode = M_UNQ;
      add_event(EV_BYTE, c, ERR_SEP);
    end
  endfunction

  function automatic void after_quote(input logic [7:0] c);
    if (blank_char(c)) begin
      parse_mode = M_AFTERQ;
    end else if (c == CH_COMMA) begin
      parse_mode = M_FSTART;
      add_event(EV_FEND, 8'h00, ERR_SEP);
    end else if (record_break(c)) begin
      close_record(c);
    end else begin
      raise_error(c, ERR_SEP);
    end
  endfunction

  // expected results of one accepted input, last one flagged
  function automatic void tokenize_step(input logic [7:0] c, input logic eoi);
    int           before_count;
    token_event_t e;
    before_count = pending_events.size();
    if (eoi) begin
      case (parse_mode)
        M_FSTART, M_UNQ, M_QSEEN, M_AFTERQ: begin
          add_event(EV_FEND, 8'h00, ERR_SEP);
          add_event(EV_REND, 8'h00, ERR_SEP);
        end
        M_QUO: add_event(EV_ERR, 8'h00, ERR_UNTERM);
        default: ;
      endcase
      parse_mode = M_REC;
    end else begin
      case (parse_mode)
        M_FSTART: start_field(c);
        M_UNQ: begin
          if (c == CH_COMMA) begin
            parse_mode = M_FSTART;
            add_event(EV_FEND, 8'h00, ERR_SEP);
          end else if (record_break(c)) begin
            close_record(c);
          end else if (c == CH_QUOTE) begin
            raise_error(c, ERR_QUOTE);
          end else begin
            add_event(EV_BYTE, c, ERR_SEP);
          end
        end
        M_QUO: begin
          if (record_break(c)) begin
            raise_error(c, ERR_UNTERM);
          end else if (c == CH_QUOTE) begin
            parse_mode = M_QSEEN;
          end else begin
            add_event(EV_BYTE, c, ERR_SEP);
          end
        end
        M_QSEEN: begin
          // doubled quote stands for one quote
          if (c == CH_QUOTE) begin
            parse_mode = M_QUO;
            add_event(EV_BYTE, c, ERR_SEP);
          end else begin
            after_quote(c);
          end
        end
        M_AFTERQ: after_quote(c);
        M_DROP: begin
          if (line_end(c)) parse_mode = M_REC;
        end
        default: begin
          // record start skips blank lines
          if (line_end(c)) parse_mode = M_REC;
          else start_field(c);
        end
      endcase
    end
    if (pending_events.size() > before_count) begin
      e = pending_events.pop_back();
      e.last = 1'b1;
      pending_events.push_back(e);
    end
  endfunction

  // stimulus helpers
  function automatic void push_text(input logic [7:0] c);
    text_item_t t;
    t.text = c;
    t.eoi  = 1'b0;
    text_queue.push_back(t);
  endfunction

  function automatic void push_end();
    text_item_t t;
    t.text = 8'($urandom_range(0, 255));
    t.eoi  = 1'b1;
    text_queue.push_back(t);
  endfunction

  function automatic logic [7:0] blank_byte();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (record_break(c) || c == CH_COMMA || c == CH_QUOTE);
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, want);
    mismatches++;
  endtask

  // stimulus: directed text first, then random records
  initial begin
    int nfields;
    int len;

    // blank line, blanks before a quoted field with a doubled quote, blank after it
    push_text(CH_LF);
    push_text(CH_SPACE);
    push_text(CH_TAB);
    push_text(CH_QUOTE);
    push_text("a");
    push_text(CH_QUOTE);
    push_text(CH_QUOTE);
    push_text(CH_QUOTE);
    push_text(CH_SPACE);
    push_text(CH_COMMA);
    // extreme bytes, then a quote inside an unquoted field, rest of line dropped
    push_text(8'hFF);
    push_text(8'h00);
    push_text(CH_QUOTE);
    push_text(CH_LF);
    // text after a closing quote
    push_text(CH_QUOTE);
    push_text("b");
    push_text(CH_QUOTE);
    push_text("z");
    push_text(CH_CR);
    // line of blanks only
    push_text(CH_SPACE);
    push_text(CH_CR);
    // sub character ends the record, dropping up to cr
    push_text("c");
    push_text(CH_SUB);
    push_text(CH_CR);
    // line break inside quotes, end of input inside quotes and at record start
    push_text(CH_QUOTE);
    push_text(CH_LF);
    push_text(CH_QUOTE);
    push_end();
    push_end();

    // mostly well-formed records with random content, some broken fields
    while (text_queue.size() < RANDOM_ITEMS + 30) begin
      nfields = $urandom_range(1, 4);
      for (int f = 0; f < nfields; f++) begin
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) push_text(blank_byte());
        len = $urandom_range(0, 5);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            repeat (len) push_text(plain_byte());
            if ($urandom_range(0, 4) == 0) push_text(blank_byte());
          end
          5, 6, 7, 8: begin
            push_text(CH_QUOTE);
            repeat (len) begin
              case ($urandom_range(0, 7))
                0: push_text(CH_COMMA);
                1: begin
                  push_text(CH_QUOTE);
                  push_text(CH_QUOTE);
                end
                2: push_text(blank_byte());
                default: push_text(plain_byte());
              endcase
            end
            push_text(CH_QUOTE);
            if ($urandom_range(0, 3) == 0) push_text(blank_byte());
          end
          default: begin
            repeat ($urandom_range(1, 3)) push_text(8'($urandom_range(0, 255)));
          end
        endcase
        if (f < nfields - 1) push_text(CH_COMMA);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          push_text(CH_CR);
          push_text(CH_LF);
        end
        4, 5: push_text(CH_LF);
        6: push_text(CH_CR);
        7: begin
          push_text(CH_SUB);
          repeat ($urandom_range(0, 2)) push_text(plain_byte());
          push_text(CH_CR);
          push_text(CH_LF);
        end
        8: push_end();
        default: begin
          push_text(CH_CR);
          push_text(CH_LF);
          push_text(CH_CR);
          push_text(CH_LF);
        end
      endcase
    end

    // wait for every transfer in, every result out, then a short drain
    @(negedge rst);
    while (text_queue.size() != 0 || in_valid) @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // input driver, changes on the falling edge
  always @(negedge clk) begin
    text_item_t t;
    if (!rst && (!in_valid || in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (text_queue.size() != 0) begin
        if (!calm && $urandom_range(0, 15) < in_rate) begin
          in_gap = $urandom_range(1, 13) - 1;
          in_valid <= 1'b0;
        end else begin
          t = text_queue.pop_front();
          in_valid     <= 1'b1;
          text_byte    <= t.text;
          end_of_input <= t.eoi;
          items_sent++;
          if (items_sent % 64 == 0) in_rate = $urandom_range(0, 4);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall driver
  always @(negedge clk) begin
    if (cycles % 64 == 0) out_rate = $urandom_range(0, 4);
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 15) < out_rate) begin
      out_gap = $urandom_range(1, 13) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: checks each result transfer, then predicts from each input transfer
  always @(posedge clk) begin
    token_event_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      calm = (text_queue.size() < CALM_ITEMS);
      in_fire = !rst && in_valid && in_ready;
      if (!rst && out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          report_mismatch("result with none expected", int'(event_kind), -1);
        end else begin
          want = pending_events.pop_front();
          if (event_kind !== want.kind)
            report_mismatch("event_kind", int'(event_kind), int'(want.kind));
          if (field_byte !== want.data)
            report_mismatch("field_byte", int'(field_byte), int'(want.data));
          if (error_code !== want.code)
            report_mismatch("error_code", int'(error_code), int'(want.code));
          if (last_of_run !== want.last)
            report_mismatch("last_of_run", int'(last_of_run), int'(want.last));
        end
        results_seen++;
      end
      if (in_fire) tokenize_step(text_byte, end_of_input);
    end
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/csvft_pkg.sv
hw/rtl/csvft_front.sv
hw/rtl/csvft_queue.sv
hw/rtl/csvft_back.sv
hw/rtl/csv_field_tokenizer.sv
bench/csv_field_tokenizer_test.sv
